FILE: sv/assert_macros.svh
// assertion macros used by the lock core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define KCL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define KCL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/kcl_pkg.sv
// types, constants and helper functions of the keypad code lock
package kcl_pkg;

   localparam int DIGITS_DEF = 4;
   localparam int RESET_CODE = 1234;
   localparam int OUT_VALUE_W = 14;
   localparam int OUT_LENGTH_W = 3;
   localparam int KEY_W = 5;

   // special key codes
   localparam logic [KEY_W-1:0] KEY_BACK = 5'd4;
   localparam logic [KEY_W-1:0] KEY_CHANGE = 5'd8;
   localparam logic [KEY_W-1:0] KEY_ENTER = 5'd16;

   // event codes reported with each result
   typedef enum logic [2:0] {
      EV_NONE = 3'd0,
      EV_OK = 3'd1,
      EV_ERR = 3'd2,
      EV_CHANGE = 3'd3,
      EV_CHANGED = 3'd4
   } ev_type;

   // decoded key
   typedef struct packed {
      logic       is_digit;
      logic [3:0] digit;
      logic       is_back;
      logic       is_change;
      logic       is_enter;
   } key_dec_type;

   // width that holds the largest entry, never below the output width
   function automatic int entry_width(input int digits);
      int p;
      int w;
      p = 1;
      for (int i = 0; i < digits; i++) p = p * 10;
      w = $clog2(p);
      return (w > OUT_VALUE_W) ? w : OUT_VALUE_W;
   endfunction

   // exact x / 10 for any 32-bit x by reciprocal multiply
   function automatic logic [31:0] div10(input logic [31:0] x);
      logic [63:0] p;
      p = {32'd0, x} * 64'h0000_0000_CCCC_CCCD;
      return {3'd0, p[63:35]};
   endfunction

endpackage

FILE: sv/kcl_key_decode.sv
// key code decoder: digit value and command keys
module kcl_key_decode (
   input  logic [kcl_pkg::KEY_W-1:0] key,
   output kcl_pkg::key_dec_type      dec
);
   import kcl_pkg::*;

   // digit map of the 4x4 matrix, row-major
   always_comb begin
      dec = '0;
      case (key)
         5'd1: begin dec.is_digit = 1'b1; dec.digit = 4'd1; end
         5'd2: begin dec.is_digit = 1'b1; dec.digit = 4'd2; end
         5'd3: begin dec.is_digit = 1'b1; dec.digit = 4'd3; end
         5'd5: begin dec.is_digit = 1'b1; dec.digit = 4'd4; end
         5'd6: begin dec.is_digit = 1'b1; dec.digit = 4'd5; end
         5'd7: begin dec.is_digit = 1'b1; dec.digit = 4'd6; end
         5'd9: begin dec.is_digit = 1'b1; dec.digit = 4'd7; end
         5'd10: begin dec.is_digit = 1'b1; dec.digit = 4'd8; end
         5'd11: begin dec.is_digit = 1'b1; dec.digit = 4'd9; end
         5'd14: begin dec.is_digit = 1'b1; dec.digit = 4'd0; end
         KEY_BACK: dec.is_back = 1'b1;
         KEY_CHANGE: dec.is_change = 1'b1;
         KEY_ENTER: dec.is_enter = 1'b1;
         default: dec = '0;
      endcase
   end

endmodule

FILE: sv/kcl_core.sv
// lock state registers and the per-key update logic
`include "assert_macros.svh"

module kcl_core #(
   parameter int DIGITS = kcl_pkg::DIGITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step_en,
   input  logic [kcl_pkg::KEY_W-1:0]    key,
   output logic [kcl_pkg::OUT_VALUE_W-1:0]  entry_nxt,
   output logic [kcl_pkg::OUT_LENGTH_W-1:0] length_nxt,
   output logic                         login_nxt,
   output logic                         change_nxt,
   output kcl_pkg::ev_type              ev_nxt
);
   import kcl_pkg::*;

   localparam int ENTRY_W = entry_width(DIGITS);
   localparam int CNT_W = ($clog2(DIGITS + 1) > OUT_LENGTH_W) ?
                          $clog2(DIGITS + 1) : OUT_LENGTH_W;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DIGITS);

   logic [ENTRY_W-1:0] entry_ff, entry_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ENTRY_W-1:0] code_ff, code_in;
   logic               login_ff, login_in;
   logic               change_ff, change_in;
   ev_type             ev_in;
   key_dec_type        dec;
   logic [ENTRY_W+3:0] append_val;
   logic [ENTRY_W-1:0] back_val;

   kcl_key_decode u_decode (
      .key (key),
      .dec (dec)
   );

   // entry times ten plus the new digit, and entry over ten
   assign append_val = ({4'd0, entry_ff} << 3) + ({4'd0, entry_ff} << 1)
                       + (ENTRY_W + 4)'(dec.digit);
   assign back_val = ENTRY_W'(div10(32'(entry_ff)));

   // next state for one key
   always_comb begin
      entry_in = entry_ff;
      count_in = count_ff;
      code_in = code_ff;
      login_in = login_ff;
      change_in = change_ff;
      ev_in = EV_NONE;
      if (dec.is_digit) begin
         if (count_ff < CNT_FULL) begin
            entry_in = ENTRY_W'(append_val);
            count_in = count_ff + 1'b1;
         end
      end else if (dec.is_back) begin
         if (count_ff != '0) begin
            entry_in = back_val;
            count_in = count_ff - 1'b1;
         end
      end else if (dec.is_change) begin
         if (login_ff) begin
            entry_in = '0;
            count_in = '0;
            change_in = 1'b1;
            ev_in = EV_CHANGE;
         end
      end else if (dec.is_enter) begin
         if (!change_ff) begin
            if (entry_ff == code_ff) begin
               login_in = 1'b1;
               ev_in = EV_OK;
            end else begin
               entry_in = '0;
               count_in = '0;
               login_in = 1'b0;
               ev_in = EV_ERR;
            end
         end else if (count_ff == CNT_FULL) begin
            code_in = entry_ff;
            entry_in = '0;
            count_in = '0;
            change_in = 1'b0;
            login_in = 1'b0;
            ev_in = EV_CHANGED;
         end
      end
   end

   // state update on each transfer out of the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         count_ff <= '0;
         code_ff <= ENTRY_W'(RESET_CODE);
         login_ff <= 1'b0;
         change_ff <= 1'b0;
      end else if (step_en) begin
         entry_ff <= entry_in;
         count_ff <= count_in;
         code_ff <= code_in;
         login_ff <= login_in;
         change_ff <= change_in;
      end
   end

   // result fields are the state after the key
   assign entry_nxt = entry_in[OUT_VALUE_W-1:0];
   assign length_nxt = count_in[OUT_LENGTH_W-1:0];
   assign login_nxt = login_in;
   assign change_nxt = change_in;
   assign ev_nxt = ev_in;

   `KCL_ASSERT(a_change_needs_login, clock, reset, !change_ff || login_ff, "change mode without login")
   `KCL_ASSERT(a_count_range, clock, reset, count_ff <= CNT_FULL, "digit count above limit")
   `KCL_ASSERT_IMP(a_changed_clears, clock, reset, step_en && ev_in == EV_CHANGED, count_ff == '0 && !change_ff && !login_ff, "code change did not clear state")

endmodule

FILE: sv/keypad_code_lock.sv
// keypad code lock: top level with input and result registers
// a key passes through the input register, then the result register, before its result can transfer
// throughput: one key per cycle while the result is not stalled, as the lock state updates on each key
// a stalled result holds the input register, which then stalls the next key
// reset (synchronous, active high): entry empty, code 1234, logged out, no change
module keypad_code_lock #(
   parameter int DIGITS = kcl_pkg::DIGITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [kcl_pkg::KEY_W-1:0]         req_key,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [kcl_pkg::OUT_VALUE_W-1:0]   rsp_entry_value,
   output logic [kcl_pkg::OUT_LENGTH_W-1:0]  rsp_entry_length,
   output logic                              rsp_logged_in,
   output logic                              rsp_change_active,
   output logic [2:0]                        rsp_event_res
);
   import kcl_pkg::*;

   logic                    in_valid_ff;
   logic [KEY_W-1:0]        in_key_ff;
   logic                    out_valid_ff;
   logic [OUT_VALUE_W-1:0]  out_value_ff;
   logic [OUT_LENGTH_W-1:0] out_length_ff;
   logic                    out_login_ff;
   logic                    out_change_ff;
   ev_type                  out_ev_ff;
   logic                    out_adv;
   logic                    step_en;
   logic [OUT_VALUE_W-1:0]  entry_nxt;
   logic [OUT_LENGTH_W-1:0] length_nxt;
   logic                    login_nxt;
   logic                    change_nxt;
   ev_type                  ev_nxt;

   // flow control between the two register stages
   assign out_adv = !out_valid_ff || !rsp_stall;
   assign step_en = in_valid_ff && out_adv;
   assign req_stall = in_valid_ff && !out_adv;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_key_ff <= req_key;
      end
   end

   kcl_core #(
      .DIGITS (DIGITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_en),
      .key        (in_key_ff),
      .entry_nxt  (entry_nxt),
      .length_nxt (length_nxt),
      .login_nxt  (login_nxt),
      .change_nxt (change_nxt),
      .ev_nxt     (ev_nxt)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_adv) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         out_value_ff <= entry_nxt;
         out_length_ff <= length_nxt;
         out_login_ff <= login_nxt;
         out_change_ff <= change_nxt;
         out_ev_ff <= ev_nxt;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_entry_value = out_value_ff;
   assign rsp_entry_length = out_length_ff;
   assign rsp_logged_in = out_login_ff;
   assign rsp_change_active = out_change_ff;
   assign rsp_event_res = out_ev_ff;

endmodule

FILE: bench/keypad_code_lock_tb.sv
// self-checking testbench for the keypad code lock: random bursts, stalls, state predictor
`timescale 1ns / 100ps

module keypad_code_lock_tb;
   import kcl_pkg::*;

   localparam int DIGITS = kcl_pkg::DIGITS_DEF;
   localparam int KEY_COUNT = 800;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 10;

   // receiver stall modes
   localparam int STALL_NONE = 0;
   localparam int STALL_PATTERN = 1;
   localparam int STALL_HEAVY = 2;
   localparam int STALL_LIGHT = 3;

   typedef struct {
      logic [31:0] entry;
      logic [2:0]  count;
      logic [31:0] code;
      logic        login;
      logic        change;
   } lock_state_type;

   typedef struct {
      logic [OUT_VALUE_W-1:0]  value;
      logic [OUT_LENGTH_W-1:0] length;
      logic                    login;
      logic                    change;
      ev_type                  ev;
   } lock_result_type;

   typedef struct {
      lock_state_type  st;
      lock_result_type res;
   } lock_step_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [KEY_W-1:0]        req_key = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [OUT_VALUE_W-1:0]  rsp_entry_value;
   logic [OUT_LENGTH_W-1:0] rsp_entry_length;
   logic                    rsp_logged_in;
   logic                    rsp_change_active;
   logic [2:0]              rsp_event_res;

   logic [KEY_W-1:0] key_queue[$];
   lock_result_type  expected_results[$];
   lock_state_type   lock_now;
   lock_state_type   planned_lock;
   lock_step_type    key_effect;
   lock_result_type  want_result;
   int               fail_count = 0;
   int               cycle_count = 0;
   int               used_keys = 0;
   int               burst_left = 0;
   int               gap_left = 0;
   int               stall_mode = STALL_NONE;
   int               stall_left = 0;
   logic [31:0]      stall_pattern = '0;
   logic [4:0]       pattern_idx = '0;

   keypad_code_lock #(
      .DIGITS(DIGITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_key(req_key),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_entry_value(rsp_entry_value),
      .rsp_entry_length(rsp_entry_length),
      .rsp_logged_in(rsp_logged_in),
      .rsp_change_active(rsp_change_active),
      .rsp_event_res(rsp_event_res)
   );

   always #6 clock = ~clock;

   // lock state after reset
   function automatic lock_state_type lock_reset_state();
      lock_state_type s;
      s.entry = '0;
      s.count = '0;
      s.code = RESET_CODE;
      s.login = 1'b0;
      s.change = 1'b0;
      return s;
   endfunction

   // decimal digit of a key, -1 for keys that are not digits
   function automatic int key_digit_of(input logic [KEY_W-1:0] k);
      case (k)
         5'd1: return 1;
         5'd2: return 2;
         5'd3: return 3;
         5'd5: return 4;
         5'd6: return 5;
         5'd7: return 6;
         5'd9: return 7;
         5'd10: return 8;
         5'd11: return 9;
         5'd14: return 0;
         default: return -1;
      endcase
   endfunction

   // key that types a decimal digit
   function automatic logic [KEY_W-1:0] digit_key(input int d);
      return (d == 0) ? 5'd14 : KEY_W'(d + (d - 1) / 3);
   endfunction

   // keys that do nothing at all
   function automatic logic [KEY_W-1:0] unused_key(input int i);
      case (i)
         0: return 5'd0;
         1: return 5'd12;
         2: return 5'd13;
         3: return 5'd15;
         default: return 5'd31;
      endcase
   endfunction

   // next lock state and the result one key press gives
   function automatic lock_step_type apply_key(input lock_state_type s,
                                               input logic [KEY_W-1:0] k);
      lock_step_type r;
      int d;
      r.st = s;
      r.res.ev = EV_NONE;
      d = key_digit_of(k);
      if (d >= 0) begin
         if (s.count < DIGITS) begin
            r.st.entry = s.entry * 10 + d;
            r.st.count = s.count + 3'd1;
         end
      end else if (k == KEY_BACK) begin
         if (s.count != 0) begin
            r.st.entry = s.entry / 10;
            r.st.count = s.count - 3'd1;
         end
      end else if (k == KEY_CHANGE) begin
         if (s.login) begin
            r.st.entry = '0;
            r.st.count = '0;
            r.st.change = 1'b1;
            r.res.ev = EV_CHANGE;
         end
      end else if (k == KEY_ENTER) begin
         if (!s.change) begin
            if (s.entry == s.code) begin
               r.st.login = 1'b1;
               r.res.ev = EV_OK;
            end else begin
               r.st.entry = '0;
               r.st.count = '0;
               r.st.login = 1'b0;
               r.res.ev = EV_ERR;
            end
         end else if (s.count == DIGITS) begin
            r.st.code = s.entry;
            r.st.entry = '0;
            r.st.count = '0;
            r.st.change = 1'b0;
            r.st.login = 1'b0;
            r.res.ev = EV_CHANGED;
         end
      end
      r.res.value = r.st.entry[OUT_VALUE_W-1:0];
      r.res.length = r.st.count;
      r.res.login = r.st.login;
      r.res.change = r.st.change;
      return r;
   endfunction

   // queue one key, tracking the lock state it will leave behind
   task automatic send_key(input logic [KEY_W-1:0] k);
      lock_step_type s;
      s = apply_key(planned_lock, k);
      planned_lock = s.st;
      key_queue.push_back(k);
      if (key_digit_of(k) >= 0 || k == KEY_BACK || k == KEY_CHANGE || k == KEY_ENTER)
         used_keys++;
   endtask

   task automatic clear_entry_keys();
      while (planned_lock.count != 0) send_key(KEY_BACK);
   endtask

   // four digits, most significant first
   task automatic type_code(input int code);
      int div;
      div = 1000;
      repeat (4) begin
         send_key(digit_key((code / div) % 10));
         div = div / 10;
      end
   endtask

   // type the current code, sometimes with a slip that is erased, then confirm
   task automatic login_keys();
      if ($urandom_range(0, 3) != 0) clear_entry_keys();
      if ($urandom_range(0, 4) == 0) begin
         send_key(digit_key($urandom_range(0, 9)));
         send_key(KEY_BACK);
      end
      type_code(int'(planned_lock.code));
      send_key(KEY_ENTER);
   endtask

   // log in, enter change mode and store a new code
   task automatic change_code_keys();
      int new_code;
      int pick;
      if (!planned_lock.login) login_keys();
      send_key(KEY_CHANGE);
      pick = $urandom_range(0, 9);
      new_code = (pick == 0) ? 0 : (pick == 1) ? 9999 : $urandom_range(0, 9999);
      // short entry confirmed in change mode
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 3)) send_key(digit_key($urandom_range(0, 9)));
         send_key(KEY_ENTER);
         clear_entry_keys();
      end
      type_code(new_code);
      if ($urandom_range(0, 5) == 0) send_key(digit_key($urandom_range(0, 9)));
      send_key(KEY_ENTER);
   endtask

   task automatic wrong_code_keys();
      if ($urandom_range(0, 2) != 0) clear_entry_keys();
      repeat ($urandom_range(0, 5)) send_key(digit_key($urandom_range(0, 9)));
      send_key(KEY_ENTER);
   endtask

   task automatic check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // driver: bursts of key transfers with random gaps, prediction on each transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_key <= '0;
         lock_now = lock_reset_state();
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            key_effect = apply_key(lock_now, req_key);
            lock_now = key_effect.st;
            expected_results.push_back(key_effect.res);
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (key_queue.size() != 0) begin
            req_valid <= 1'b1;
            req_key <= key_queue.pop_front();
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 20);
               gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall: a new random mode whenever the mode countdown runs out
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(STALL_NONE, STALL_LIGHT);
            stall_pattern = $urandom;
            stall_left = $urandom_range(50, 300);
         end else begin
            stall_left--;
         end
         pattern_idx = pattern_idx + 5'd1;
         case (stall_mode)
            STALL_PATTERN: rsp_stall <= stall_pattern[pattern_idx];
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 7) == 0);
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   // monitor: each result transfer against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result with nothing expected, actual value %0d length %0d event %0d",
               $time, rsp_entry_value, rsp_entry_length, rsp_event_res);
            fail_count++;
         end else begin
            want_result = expected_results.pop_front();
            check_field("entry_value", want_result.value, rsp_entry_value);
            check_field("entry_length", want_result.length, rsp_entry_length);
            check_field("logged_in", want_result.login, rsp_logged_in);
            check_field("change_active", want_result.change, rsp_change_active);
            check_field("event_res", want_result.ev, rsp_event_res);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      planned_lock = lock_reset_state();

      // directed: empty backspace, change while logged out, unused keys
      send_key(KEY_BACK);
      send_key(KEY_CHANGE);
      for (int i = 0; i < 5; i++) send_key(unused_key(i));
      // wrong code on an empty entry
      send_key(KEY_ENTER);
      // reset code, a digit on a full entry, then login
      type_code(RESET_CODE);
      send_key(digit_key(9));
      send_key(KEY_ENTER);
      // change mode twice, short confirm, then store 0000
      send_key(KEY_CHANGE);
      send_key(KEY_CHANGE);
      repeat (3) send_key(digit_key(0));
      send_key(KEY_ENTER);
      send_key(digit_key(0));
      send_key(KEY_ENTER);

      // random: mostly well-formed login and change sequences
      while (used_keys < KEY_COUNT) begin
         case ($urandom_range(0, 9))
            0, 1, 2: login_keys();
            3, 4: change_code_keys();
            5, 6: wrong_code_keys();
            7, 8: repeat ($urandom_range(1, 8)) send_key(KEY_W'($urandom_range(1, 16)));
            default: repeat ($urandom_range(1, 4)) send_key(KEY_W'($urandom_range(0, 31)));
         endcase
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (key_queue.size() != 0 || req_valid) @(negedge clock);
      while (expected_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: keypad_code_lock.f
+incdir+sv
sv/kcl_pkg.sv
sv/kcl_key_decode.sv
sv/kcl_core.sv
sv/keypad_code_lock.sv
bench/keypad_code_lock_tb.sv
